@@ design/vrti_pkg.sv @@
// ---------------------------------------------------------------------------
// vrti_pkg: shared constants for the record to impedance converter
// Field widths, pipeline depths and register indexes used by the converter,
// its divider and its checker.
// ---------------------------------------------------------------------------
`default_nettype none

package vrti_pkg;

   localparam int SAMPLE_WIDTH = 32;

   localparam int VAL_W      = 32;
   localparam int HZ_W       = 40;
   localparam int IDX_W      = 16;
   localparam int FREQ_W     = 56;
   localparam int REQ_DATA_W = 6 * VAL_W + IDX_W;
   localparam int RSP_DATA_W = FREQ_W + 6 * VAL_W;
   localparam int RSP_USER_W = 2;

   // divider geometry: quotient bits 32..0 plus one setup and one rounding stage
   localparam int DEN_W      = 64;
   localparam int QUO_BITS   = 33;
   localparam int DIV_NUM_W  = 92;
   localparam int DIV_LAT    = QUO_BITS + 2;
   localparam int PIPE_DEPTH = 2 * DIV_LAT + 10;

   localparam logic [0:0] CSR_START_HZ = 1'b0;
   localparam logic [0:0] CSR_STEP_HZ  = 1'b1;

   localparam logic [63:0] ONE_Q56 = 64'h0100_0000_0000_0000;
   localparam logic [33:0] ONE_Q28 = 34'h0_1000_0000;
   localparam logic [31:0] RES_SAT = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

@@ design/vna_record_to_impedance.sv @@
// ---------------------------------------------------------------------------
// vna_record_to_impedance: measurement record to S-parameters and impedance
// Forms S11, S21 in Q3.28, the point frequency, and R/X against 50 ohms.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one record per transaction (fwd, refl, thru samples and
//   the sweep point index); rsp_* returns the point frequency, S11, S21,
//   resistance and reactance, with status flags in rsp_tuser. csr_* writes
//   start_hz (index 0) and step_hz (index 1); csr_ready is always high. The
//   user must write registers only while no record is in flight; unchecked.
//   From req transaction to rsp_tvalid a record passes through four input
//   stages, a 35-stage divider bank for S11/S21, five impedance stages, a
//   second 35-stage divider bank for R/X, and the output register. The
//   dividers produce one quotient bit per stage, so unless the output stalls
//   a record enters every cycle and one result leaves every cycle.
//   A record whose frequency is zero is dropped and leaves no transaction.
//   Reset clears both frequency registers and empties the pipeline.
//   While rsp_tvalid is high and rsp_tready low, the whole pipeline holds
//   and req_tready is low; the waiting result stays unchanged.
// ---------------------------------------------------------------------------
`default_nettype none

module vna_record_to_impedance #(
   parameter int SAMPLE_WIDTH = vrti_pkg::SAMPLE_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // fwd_re, fwd_im, refl_re, refl_im, thru_re, thru_im, point_index
   input  wire logic [vrti_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // freq_out_hz, s11_re, s11_im, s21_re, s21_im, resistance, reactance
   output logic      [vrti_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // reference_zero, saturated
   output logic      [vrti_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [0:0]                       csr_index,
   input  wire logic [vrti_pkg::HZ_W-1:0]        csr_data
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int VW    = vrti_pkg::VAL_W;
   localparam int DW    = vrti_pkg::DEN_W;
   localparam int FW    = vrti_pkg::FREQ_W;
   localparam int NW    = vrti_pkg::DIV_NUM_W;
   localparam int LAT   = vrti_pkg::DIV_LAT;
   localparam int DEPTH = vrti_pkg::PIPE_DEPTH;
   localparam int IDX0  = 6 * VW;
   localparam logic [69:0] RES_GAIN   = 70'd50;
   localparam logic [38:0] REACT_GAIN = 39'd100;

   typedef struct packed {
      logic [FW-1:0] freq;
      logic          refz;
      logic          keep;
   } sb1_type;

   typedef struct packed {
      logic [FW-1:0] freq;
      logic          keep;
      logic          refz;
      logic          ssat;
      logic          dz;
      logic [VW-1:0] s11r;
      logic [VW-1:0] s11i;
      logic [VW-1:0] s21r;
      logic [VW-1:0] s21i;
   } sb2_type;

   function automatic logic [64:0] sign_mag(input logic signed [64:0] s);
      logic [64:0] neg_s;
      neg_s    = 65'(0) - 65'(s);
      sign_mag = s[64] ? {1'b1, neg_s[63:0]} : {1'b0, s[63:0]};
   endfunction

   logic                  en;
   logic [DEPTH-1:0]      valid_ff;
   logic [vrti_pkg::HZ_W-1:0] start_ff;
   logic [vrti_pkg::HZ_W-1:0] step_ff;

   // stage 1: captured samples
   logic signed [SW-1:0]  fr_ff, fi_ff, ar_ff, ai_ff, br_ff, bi_ff;
   logic [vrti_pkg::IDX_W-1:0] idx_ff;
   // stage 2: products
   logic signed [63:0]    frfr_ff, fifi_ff;
   logic signed [63:0]    arfr_ff, aifi_ff, aifr_ff, arfi_ff;
   logic signed [63:0]    brfr_ff, bifi_ff, bifr_ff, brfi_ff;
   logic [FW-1:0]         stepidx_ff;
   // stage 3: sums
   logic [DW-1:0]         den3_ff;
   logic signed [64:0]    nar_ff, nai_ff, nbr_ff, nbi_ff;
   logic [FW-1:0]         freq3_ff;
   // stage 4: sign and magnitude
   logic [64:0]           sar_ff, sai_ff, sbr_ff, sbi_ff;
   logic [DW-1:0]         den4_ff;
   logic                  refz4_ff;
   logic                  keep4_ff;
   logic [FW-1:0]         freq4_ff;
   logic [64:0]           sar_in, sai_in, sbr_in, sbi_in;
   logic [DW-1:0]         div1_den;

   logic [VW-1:0]         q11r, q11i, q21r, q21i;
   logic                  t11r, t11i, t21r, t21i;
   sb1_type               sb1_ff [0:LAT-1];
   sb1_type               sb1_out;

   // impedance stages
   sb2_type               i1_in;
   sb2_type               i4_in;
   sb2_type               i1_ff, i2_ff, i3_ff, i4_ff, i5_ff;
   logic signed [VW-1:0]  rq, iq;
   logic signed [33:0]    dq;
   logic [VW-1:0]         rm_in, imm_in;
   logic [32:0]           dm_in;
   logic [VW-1:0]         rm_ff, imm1_ff, imm2_ff, imm3_ff, imm4_ff;
   logic [32:0]           dm_ff;
   logic                  ineg1_ff, ineg2_ff, ineg3_ff, ineg4_ff, ineg5_ff;
   logic [63:0]           rr_ff, ii_ff, dd_ff;
   logic [63:0]           sumsq_ff, denz3_ff, denz4_ff;
   logic [63:0]           rdiff_ff;
   logic                  rneg4_ff, rneg5_ff;
   logic [69:0]           numr_ff;
   logic [38:0]           numx_ff;
   logic [DW-1:0]         den5_ff;

   logic [VW-1:0]         qres, qreac;
   logic                  tres, treac;
   sb2_type               sb2_ff [0:LAT-1];
   sb2_type               sb2_out;

   logic [vrti_pkg::RSP_DATA_W-1:0] data_ff;
   logic [vrti_pkg::RSP_USER_W-1:0] user_ff;
   logic                  keep_ff;
   logic [VW-1:0]         res_out, reac_out;
   logic                  sat_out;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         step_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            vrti_pkg::CSR_START_HZ: start_ff <= csr_data;
            vrti_pkg::CSR_STEP_HZ:  step_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_tvalid};
      end
   end

   always_comb begin
      sar_in   = sign_mag(nar_ff);
      sai_in   = sign_mag(nai_ff);
      sbr_in   = sign_mag(nbr_ff);
      sbi_in   = sign_mag(nbi_ff);
      div1_den = refz4_ff ? DW'(1) : den4_ff;
   end

   // front end: capture, multiply, sum, sign/magnitude
   always_ff @(posedge clock) begin
      if (en) begin
         fr_ff  <= req_tdata[0*VW +: SW];
         fi_ff  <= req_tdata[1*VW +: SW];
         ar_ff  <= req_tdata[2*VW +: SW];
         ai_ff  <= req_tdata[3*VW +: SW];
         br_ff  <= req_tdata[4*VW +: SW];
         bi_ff  <= req_tdata[5*VW +: SW];
         idx_ff <= req_tdata[IDX0 +: vrti_pkg::IDX_W];

         frfr_ff    <= fr_ff * fr_ff;
         fifi_ff    <= fi_ff * fi_ff;
         arfr_ff    <= ar_ff * fr_ff;
         aifi_ff    <= ai_ff * fi_ff;
         aifr_ff    <= ai_ff * fr_ff;
         arfi_ff    <= ar_ff * fi_ff;
         brfr_ff    <= br_ff * fr_ff;
         bifi_ff    <= bi_ff * fi_ff;
         bifr_ff    <= bi_ff * fr_ff;
         brfi_ff    <= br_ff * fi_ff;
         stepidx_ff <= FW'(step_ff) * FW'(idx_ff);

         den3_ff  <= $unsigned(frfr_ff) + $unsigned(fifi_ff);
         nar_ff   <= 65'(arfr_ff) + 65'(aifi_ff);
         nai_ff   <= 65'(aifr_ff) - 65'(arfi_ff);
         nbr_ff   <= 65'(brfr_ff) + 65'(bifi_ff);
         nbi_ff   <= 65'(bifr_ff) - 65'(brfi_ff);
         freq3_ff <= FW'(start_ff) + stepidx_ff;

         sar_ff   <= sar_in;
         sai_ff   <= sai_in;
         sbr_ff   <= sbr_in;
         sbi_ff   <= sbi_in;
         den4_ff  <= den3_ff;
         refz4_ff <= den3_ff == '0;
         keep4_ff <= freq3_ff != '0;
         freq4_ff <= freq3_ff;
      end
   end

   vrti_qdiv #(.NUM_W(NW)) u_div_s11r (
      .clock(clock), .en(en), .num({sar_ff[63:0], 28'd0}), .neg(sar_ff[64]),
      .den(div1_den), .quo(q11r), .sat(t11r));
   vrti_qdiv #(.NUM_W(NW)) u_div_s11i (
      .clock(clock), .en(en), .num({sai_ff[63:0], 28'd0}), .neg(sai_ff[64]),
      .den(div1_den), .quo(q11i), .sat(t11i));
   vrti_qdiv #(.NUM_W(NW)) u_div_s21r (
      .clock(clock), .en(en), .num({sbr_ff[63:0], 28'd0}), .neg(sbr_ff[64]),
      .den(div1_den), .quo(q21r), .sat(t21r));
   vrti_qdiv #(.NUM_W(NW)) u_div_s21i (
      .clock(clock), .en(en), .num({sbi_ff[63:0], 28'd0}), .neg(sbi_ff[64]),
      .den(div1_den), .quo(q21i), .sat(t21i));

   always_ff @(posedge clock) begin
      if (en) begin
         sb1_ff[0] <= '{freq: freq4_ff, refz: refz4_ff, keep: keep4_ff};
         for (int k = 1; k < LAT; k++) begin
            sb1_ff[k] <= sb1_ff[k-1];
         end
      end
   end

   assign sb1_out = sb1_ff[LAT-1];

   // zero reference forces S11 = S21 = 0 without saturation
   always_comb begin
      i1_in.freq = sb1_out.freq;
      i1_in.keep = sb1_out.keep;
      i1_in.refz = sb1_out.refz;
      i1_in.ssat = !sb1_out.refz && (t11r || t11i || t21r || t21i);
      i1_in.dz   = 1'b0;
      i1_in.s11r = sb1_out.refz ? '0 : q11r;
      i1_in.s11i = sb1_out.refz ? '0 : q11i;
      i1_in.s21r = sb1_out.refz ? '0 : q21r;
      i1_in.s21i = sb1_out.refz ? '0 : q21i;
      rq     = signed'(i1_in.s11r);
      iq     = signed'(i1_in.s11i);
      rm_in  = rq[VW-1] ? (VW'(0) - VW'(rq)) : VW'(rq);
      imm_in = iq[VW-1] ? (VW'(0) - VW'(iq)) : VW'(iq);
      dq     = signed'(vrti_pkg::ONE_Q28) - 34'(rq);
      dm_in  = dq[33] ? 33'(34'(0) - 34'(dq)) : dq[32:0];
   end

   always_comb begin
      i4_in    = i3_ff;
      i4_in.dz = denz3_ff == '0;
   end

   // impedance: |1 - S11|^2 and 1 - |S11|^2
   always_ff @(posedge clock) begin
      if (en) begin
         i1_ff    <= i1_in;
         rm_ff    <= rm_in;
         imm1_ff  <= imm_in;
         dm_ff    <= dm_in;
         ineg1_ff <= iq[VW-1];

         i2_ff    <= i1_ff;
         rr_ff    <= rm_ff * rm_ff;
         ii_ff    <= imm1_ff * imm1_ff;
         dd_ff    <= dm_ff * dm_ff;
         imm2_ff  <= imm1_ff;
         ineg2_ff <= ineg1_ff;

         i3_ff    <= i2_ff;
         sumsq_ff <= rr_ff + ii_ff;
         denz3_ff <= dd_ff + ii_ff;
         imm3_ff  <= imm2_ff;
         ineg3_ff <= ineg2_ff;

         i4_ff    <= i4_in;
         rneg4_ff <= sumsq_ff > vrti_pkg::ONE_Q56;
         rdiff_ff <= (sumsq_ff > vrti_pkg::ONE_Q56) ? (sumsq_ff - vrti_pkg::ONE_Q56)
                                                    : (vrti_pkg::ONE_Q56 - sumsq_ff);
         denz4_ff <= denz3_ff;
         imm4_ff  <= imm3_ff;
         ineg4_ff <= ineg3_ff;

         i5_ff    <= i4_ff;
         numr_ff  <= 70'(rdiff_ff) * RES_GAIN;
         numx_ff  <= 39'(imm4_ff) * REACT_GAIN;
         den5_ff  <= i4_ff.dz ? DW'(1) : denz4_ff;
         rneg5_ff <= rneg4_ff;
         ineg5_ff <= ineg4_ff;
      end
   end

   vrti_qdiv #(.NUM_W(NW)) u_div_res (
      .clock(clock), .en(en), .num(NW'({numr_ff, 16'd0})), .neg(rneg5_ff),
      .den(den5_ff), .quo(qres), .sat(tres));
   vrti_qdiv #(.NUM_W(NW)) u_div_reac (
      .clock(clock), .en(en), .num(NW'({numx_ff, 44'd0})), .neg(ineg5_ff),
      .den(den5_ff), .quo(qreac), .sat(treac));

   always_ff @(posedge clock) begin
      if (en) begin
         sb2_ff[0] <= i5_ff;
         for (int k = 1; k < LAT; k++) begin
            sb2_ff[k] <= sb2_ff[k-1];
         end
      end
   end

   assign sb2_out = sb2_ff[LAT-1];

   always_comb begin
      res_out  = sb2_out.dz ? vrti_pkg::RES_SAT : qres;
      reac_out = sb2_out.dz ? '0 : qreac;
      sat_out  = sb2_out.ssat || sb2_out.dz || tres || treac;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= {reac_out, res_out, sb2_out.s21i, sb2_out.s21r,
                     sb2_out.s11i, sb2_out.s11r, sb2_out.freq};
         user_ff <= {sat_out, sb2_out.refz};
         keep_ff <= sb2_out.keep;
      end
   end

   assign rsp_tvalid = valid_ff[DEPTH-1] && keep_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

`default_nettype wire

@@ design/vrti_qdiv.sv @@
// ---------------------------------------------------------------------------
// vrti_qdiv: pipelined rounding divider
// Returns round(num / den), ties away from zero, signed by neg and clipped
// to the 32-bit signed range. One quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module vrti_qdiv #(
   parameter int NUM_W = vrti_pkg::DIV_NUM_W
) (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [NUM_W-1:0]            num,
   input  wire logic                        neg,
   input  wire logic [vrti_pkg::DEN_W-1:0]  den,
   output logic      [vrti_pkg::VAL_W-1:0]  quo,
   output logic                             sat
);

   localparam int QB   = vrti_pkg::QUO_BITS;
   localparam int DW   = vrti_pkg::DEN_W;
   localparam int VW   = vrti_pkg::VAL_W;
   localparam logic [QB:0] LIM_POS = (QB+1)'((64'd1 << (VW - 1)) - 64'd1);
   localparam logic [QB:0] LIM_NEG = (QB+1)'(64'd1 << (VW - 1));

   logic [DW-1:0] rem_ff [0:QB];
   logic [QB-1:0] low_ff [0:QB];
   logic [QB-1:0] q_ff   [0:QB];
   logic [DW-1:0] den_ff [0:QB];
   logic          ovf_ff [0:QB];
   logic          neg_ff [0:QB];
   logic [VW-1:0] quo_ff;
   logic          sat_ff;

   logic [DW-1:0] hi_ext;
   logic [DW:0]   trial [1:QB];
   logic          ge    [1:QB];
   logic          rnd;
   logic [QB:0]   qr;
   logic [QB:0]   limit;
   logic          sat_in;
   logic [VW-1:0] mag;
   logic [VW-1:0] quo_in;

   // quotient overflows past 2^33 when the top part already reaches den
   assign hi_ext = DW'(num[NUM_W-1:QB]);

   always_comb begin
      for (int j = 1; j <= QB; j++) begin
         trial[j] = {rem_ff[j-1], low_ff[j-1][QB-1]};
         ge[j]    = trial[j] >= {1'b0, den_ff[j-1]};
      end
   end

   always_comb begin
      rnd    = {rem_ff[QB], 1'b0} >= {1'b0, den_ff[QB]};
      qr     = {1'b0, q_ff[QB]} + (QB+1)'(rnd);
      limit  = neg_ff[QB] ? LIM_NEG : LIM_POS;
      sat_in = ovf_ff[QB] || (qr > limit);
      mag    = sat_in ? limit[VW-1:0] : qr[VW-1:0];
      quo_in = neg_ff[QB] ? (VW'(0) - mag) : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= hi_ext;
         low_ff[0] <= num[QB-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         ovf_ff[0] <= hi_ext >= den;
         neg_ff[0] <= neg;
         for (int j = 1; j <= QB; j++) begin
            rem_ff[j] <= ge[j] ? DW'(trial[j] - {1'b0, den_ff[j-1]}) : trial[j][DW-1:0];
            low_ff[j] <= {low_ff[j-1][QB-2:0], 1'b0};
            q_ff[j]   <= {q_ff[j-1][QB-2:0], ge[j]};
            den_ff[j] <= den_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
         quo_ff <= quo_in;
         sat_ff <= sat_in;
      end
   end

   assign quo = quo_ff;
   assign sat = sat_ff;

endmodule

`default_nettype wire

@@ design/vrti_checker.sv @@
// ---------------------------------------------------------------------------
// vrti_checker: port-level checks for the record to impedance converter
// Watches the result channel and flow control over time.
// ---------------------------------------------------------------------------
`default_nettype none

module vrti_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [vrti_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [vrti_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   localparam int FW = vrti_pkg::FREQ_W;
   localparam int SP = FW + 4 * vrti_pkg::VAL_W;

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // with no result waiting the input side must be open
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // zero reference gives zero s-parameters
   a_refz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[SP-1:FW] == '0)
      else $error("s-parameters nonzero with zero reference");

   // zero-frequency points never leave the block
   a_freq_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[FW-1:0] != '0)
      else $error("result with zero frequency");

endmodule

bind vna_record_to_impedance vrti_checker u_vrti_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

`default_nettype wire
